// File: sv/cap_pkg.sv
package cap_pkg;

  localparam int unsigned SLOTS      = 64;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned SID_W      = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned HASH_W     = 4 * WORD_W;
  localparam int unsigned RIGHTS_W   = 32;
  localparam int unsigned OUT_SLOT_W = 6;
  localparam int unsigned CMD_W      = 2;
  // free-slot search runs over groups of eight valid bits
  localparam int unsigned GROUP      = 8;
  localparam int unsigned NGROUPS    = (SLOTS + GROUP - 1) / GROUP;
  localparam int unsigned PAD_SLOTS  = NGROUPS * GROUP;
  localparam int unsigned CMP_W      = (SLOT_W >= SID_W) ? SLOT_W + 1 : SID_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_GRANT  = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_REVOKE = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } cap_ctrl_t;

  typedef struct packed {
    logic result_due;
    logic out_full;
  } cap_stat_t;

endpackage

// File: sv/cap_req_if.sv
interface cap_req_if
  import cap_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [SID_W-1:0]       slot_id;
  logic [WORD_W-1:0]      hash_word0;
  logic [WORD_W-1:0]      hash_word1;
  logic [WORD_W-1:0]      hash_word2;
  logic [WORD_W-1:0]      hash_word3;
  logic [RIGHTS_W-1:0]    rights_mask;

  modport source (
    output valid, cmd, slot_id, hash_word0, hash_word1, hash_word2, hash_word3,
           rights_mask,
    input  ready
  );

  modport sink (
    input  valid, cmd, slot_id, hash_word0, hash_word1, hash_word2, hash_word3,
           rights_mask,
    output ready
  );
endinterface

// File: sv/cap_rsp_if.sv
interface cap_rsp_if
  import cap_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  status;
  logic [OUT_SLOT_W-1:0] granted_slot;

  modport source (
    output valid, status, granted_slot,
    input  ready
  );

  modport sink (
    input  valid, status, granted_slot,
    output ready
  );
endinterface

// File: sv/cap_ctrl.sv
module cap_ctrl
  import cap_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  cap_stat_t stat_i,
  output cap_ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    req_ready_o    = 1'b0;
    ctrl_o.capture = 1'b0;
    ctrl_o.execute = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold while the previous result word is still waiting
        if (!stat_i.result_due || !stat_i.out_full) begin
          ctrl_o.execute = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/cap_dpath.sv
module cap_dpath
  import cap_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  cap_req_if.sink   req_i,
  cap_rsp_if.source rsp_o,
  input  cap_ctrl_t ctrl_i,
  output cap_stat_t stat_o
);

  logic [HASH_W-1:0]   hash_mem [SLOTS];
  logic [RIGHTS_W-1:0] rights_mem [SLOTS];
  logic [SLOTS-1:0]    valid_q;

  logic [CMD_W-1:0]    cmd_q;
  logic [SID_W-1:0]    sid_q;
  logic [HASH_W-1:0]   hash_in_q;
  logic [RIGHTS_W-1:0] rights_in_q;
  logic [HASH_W-1:0]   hash_rd_q;
  logic [RIGHTS_W-1:0] rights_rd_q;

  logic [NGROUPS-1:0]  grp_free_q, grp_free_d;
  logic [SLOT_W-1:0]   grp_slot_q [NGROUPS];
  logic [SLOT_W-1:0]   grp_slot_d [NGROUPS];
  logic [PAD_SLOTS-1:0] occ;

  logic [CMP_W-1:0]    rd_sid_ext, sid_ext;
  logic [SLOT_W-1:0]   rd_idx, sid_idx;
  logic                in_range;
  logic                check_ok;
  logic                free_found;
  logic [SLOT_W-1:0]   free_slot;
  logic                do_grant;
  logic                do_revoke;
  logic                result_due;
  logic                res_status;

  logic                  out_valid_q;
  logic                  status_q;
  logic [OUT_SLOT_W-1:0] slot_q;

  assign rd_sid_ext = CMP_W'(req_i.slot_id);
  assign rd_idx     = SLOT_W'(rd_sid_ext);
  assign sid_ext    = CMP_W'(sid_q);
  assign sid_idx    = SLOT_W'(sid_ext);
  assign in_range   = sid_ext < CMP_W'(SLOTS);

  // first level of the free-slot search, taken at capture time
  always_comb begin
    occ = '1;
    for (int i = 0; i < SLOTS; i++) begin
      occ[i] = valid_q[i];
    end
    for (int g = 0; g < NGROUPS; g++) begin
      grp_free_d[g] = 1'b0;
      grp_slot_d[g] = SLOT_W'(g * GROUP);
      for (int j = GROUP - 1; j >= 0; j--) begin
        if (!occ[g * GROUP + j]) begin
          grp_free_d[g] = 1'b1;
          grp_slot_d[g] = SLOT_W'(g * GROUP + j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q       <= req_i.cmd;
      sid_q       <= req_i.slot_id;
      hash_in_q   <= {req_i.hash_word3, req_i.hash_word2, req_i.hash_word1, req_i.hash_word0};
      rights_in_q <= req_i.rights_mask;
      grp_free_q  <= grp_free_d;
      for (int g = 0; g < NGROUPS; g++) begin
        grp_slot_q[g] <= grp_slot_d[g];
      end
    end
  end

  // second level: lowest group that has a free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int g = NGROUPS - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        free_found = 1'b1;
        free_slot  = grp_slot_q[g];
      end
    end
  end

  assign check_ok = in_range && valid_q[sid_idx] && ((rights_rd_q & rights_in_q) != '0)
                    && (hash_rd_q == hash_in_q);

  always_comb begin
    do_grant   = 1'b0;
    do_revoke  = 1'b0;
    result_due = 1'b0;
    res_status = 1'b1;
    unique case (cmd_e'(cmd_q))
      CMD_GRANT: begin
        result_due = 1'b1;
        do_grant   = free_found;
        res_status = !free_found;
      end
      CMD_CHECK: begin
        result_due = 1'b1;
        res_status = !check_ok;
      end
      CMD_REVOKE: begin
        do_revoke = in_range;
      end
      default: begin
        result_due = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute && do_grant) begin
      hash_mem[free_slot] <= hash_in_q;
    end
    if (ctrl_i.capture) begin
      hash_rd_q <= hash_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute && do_grant) begin
      rights_mem[free_slot] <= rights_in_q;
    end
    if (ctrl_i.capture) begin
      rights_rd_q <= rights_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.execute) begin
      if (do_grant) begin
        valid_q[free_slot] <= 1'b1;
      end
      if (do_revoke) begin
        valid_q[sid_idx] <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.execute && result_due) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute && result_due) begin
      status_q <= res_status;
      slot_q   <= do_grant ? OUT_SLOT_W'(free_slot) : '0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.granted_slot = slot_q;

  assign stat_o.result_due = result_due;
  assign stat_o.out_full   = out_valid_q && !rsp_o.ready;

endmodule

// File: sv/capability_table.sv
// Capability table: 64 slots, each with a valid mark, a 256-bit object hash and a
// 32-bit rights mask. Grant (cmd 0) takes the lowest free slot and answers with its
// number, or status 1 when the table is full; check (cmd 1) answers status 0 only for
// an in-range, valid slot whose stored rights overlap the asked mask and whose hash
// matches; revoke (cmd 2) frees a slot and sends no word, as does cmd 3. One item is
// handled at a time: the accept cycle reads the slot's hash and rights memories and
// registers the grouped free-slot search; the execute state then compares or writes
// and loads the result register. For grant and check, execute waits while an earlier
// result word has not been taken. Reset clears only the valid marks; no clearing pass.
module capability_table
  import cap_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  cap_req_if.sink   req_i,
  cap_rsp_if.source rsp_o
);

  cap_ctrl_t ctrl;
  cap_stat_t stat;
  logic      ready;

  assign req_i.ready = ready;

  cap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  cap_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

endmodule
